// ===== hdl/logical_file_table_defines.svh =====
// ---------------------------------------------------------------------------
// logical file table assertion macros
// concurrent check helpers, empty when building for synthesis
// ---------------------------------------------------------------------------
`ifndef LOGICAL_FILE_TABLE_DEFINES_SVH
`define LOGICAL_FILE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// expression must hold on every clock edge out of reset
`define LFT_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define LFT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LFT_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define LFT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define LFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/lft_pkg.sv =====
// ---------------------------------------------------------------------------
// lft_pkg
// shared types and codes of the logical file table
// ---------------------------------------------------------------------------
package lft_pkg;

    localparam int COUNT_W = 4;
    localparam logic [7:0] SA_FLAGS = 8'h60;

    typedef enum logic [1:0] {
        OP_OPEN      = 2'd0,
        OP_CLOSE     = 2'd1,
        OP_LOOKUP    = 2'd2,
        OP_CLOSE_ALL = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_TOO_MANY = 2'd1,
        STAT_ALREADY  = 2'd2,
        STAT_NOT_OPEN = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLEAR
    } t_cnt_op;

    typedef struct packed {
        logic [7:0] logical;
        logic [7:0] device;
        logic [7:0] secondary;
    } t_entry;

    typedef struct packed {
        logic    rd_en;
        logic    wr_en;
        t_cnt_op cnt_op;
    } t_tbl_ctl;

endpackage

// ===== hdl/lft_table.sv =====
// ---------------------------------------------------------------------------
// lft_table
// entry memory with one write and one registered read port, plus entry count
// ---------------------------------------------------------------------------
module lft_table
    import lft_pkg::*;
#(
    parameter int DEPTH = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_tbl_ctl                       i_ctl,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  t_entry                         i_wr_data,
    output t_entry                         o_rd_data,
    output logic [$clog2(DEPTH + 1)-1:0]   o_count
);

    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    t_entry          r_rd_data;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_comb begin
        case (i_ctl.cnt_op)
            CNT_INC:   n_count = r_count + CW'(1);
            CNT_DEC:   n_count = r_count - CW'(1);
            CNT_CLEAR: n_count = '0;
            default:   n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_count   = r_count;

endmodule

// ===== hdl/logical_file_table.sv =====
// ---------------------------------------------------------------------------
// logical_file_table
// table of open logical files: open, close, lookup and close-all
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  request | in        | i_valid / o_stall  | opcode, logical, device, sec addr
//  result  | out       | o_valid / i_stall  | status, device, sec addr, count
//
//  an item compares the stored entries in turn through the single read port,
//  stopping at a match, then does the write or the last-entry move and the
//  result load; a close-all clears the count and goes to the result load
//  the request side stalls from acceptance until the result is loaded
//  the result register holds while the output side stalls
//  synchronous active-low reset empties the table; no clearing pass
// ---------------------------------------------------------------------------
`include "logical_file_table_defines.svh"

module logical_file_table
    import lft_pkg::*;
#(
    parameter int TABLE_DEPTH = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_logical_number,
    input  logic [7:0] i_device_number,
    input  logic [7:0] i_secondary_address,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_found_device,
    output logic [7:0] o_found_secondary,
    output logic [3:0] o_open_count
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state        r_state,        n_state;
    t_opcode       r_op,           n_op;
    logic [7:0]    r_num,          n_num;
    logic [7:0]    r_dev,          n_dev;
    logic [7:0]    r_sec,          n_sec;
    logic [CW-1:0] r_idx,          n_idx;
    logic          r_pend,         n_pend;
    logic [AW-1:0] r_pend_idx,     n_pend_idx;
    t_status       r_res_status,   n_res_status;
    logic [7:0]    r_res_dev,      n_res_dev;
    logic [7:0]    r_res_sec,      n_res_sec;
    logic          r_out_valid,    n_out_valid;
    t_status       r_out_status,   n_out_status;
    logic [7:0]    r_out_dev,      n_out_dev;
    logic [7:0]    r_out_sec,      n_out_sec;
    logic [COUNT_W-1:0] r_out_count, n_out_count;

    t_tbl_ctl      w_ctl;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;
    t_entry        w_wr_data;
    t_entry        w_rd_data;
    logic [CW-1:0] w_count;
    logic [CW-1:0] w_last;
    logic          w_match;
    logic          w_more;
    logic          w_full;
    logic [CW+COUNT_W-1:0] w_cnt_ext;

    lft_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data),
        .o_count   (w_count)
    );

    // compare of the entry read in the previous cycle
    assign w_match   = r_pend && (w_rd_data.logical == r_num);
    assign w_more    = r_idx < w_count;
    assign w_full    = w_count == CW'(TABLE_DEPTH);
    assign w_last    = w_count - CW'(1);
    assign w_cnt_ext = {{COUNT_W{1'b0}}, w_count};

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_num        = r_num;
        n_dev        = r_dev;
        n_sec        = r_sec;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_pend_idx   = r_pend_idx;
        n_res_status = r_res_status;
        n_res_dev    = r_res_dev;
        n_res_sec    = r_res_sec;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_dev    = r_out_dev;
        n_out_sec    = r_out_sec;
        n_out_count  = r_out_count;
        w_ctl.rd_en  = 1'b0;
        w_ctl.wr_en  = 1'b0;
        w_ctl.cnt_op = CNT_HOLD;
        w_rd_addr    = r_idx[AW-1:0];
        w_wr_addr    = r_pend_idx;
        w_wr_data    = w_rd_data;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_op         = t_opcode'(i_opcode);
                    n_num        = i_logical_number;
                    n_dev        = i_device_number;
                    n_sec        = i_secondary_address;
                    n_idx        = '0;
                    n_pend       = 1'b0;
                    n_res_status = STAT_OK;
                    n_res_dev    = '0;
                    n_res_sec    = '0;
                    if (t_opcode'(i_opcode) == OP_CLOSE_ALL) begin
                        w_ctl.cnt_op = CNT_CLEAR;
                        n_state      = ST_DONE;
                    end else begin
                        n_state = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH: begin
                if (w_match) begin
                    n_state = ST_DONE;
                    case (r_op)
                        OP_OPEN: begin
                            n_res_status = STAT_ALREADY;
                        end
                        OP_CLOSE: begin
                            if (CW'(r_pend_idx) == w_last) begin
                                w_ctl.cnt_op = CNT_DEC;
                            end else begin
                                n_state = ST_MOVE_RD;
                            end
                        end
                        OP_LOOKUP: begin
                            n_res_dev = w_rd_data.device;
                            n_res_sec = w_rd_data.secondary;
                        end
                        default: begin
                        end
                    endcase
                end else if (w_more) begin
                    w_ctl.rd_en = 1'b1;
                    w_rd_addr   = r_idx[AW-1:0];
                    n_pend      = 1'b1;
                    n_pend_idx  = r_idx[AW-1:0];
                    n_idx       = r_idx + CW'(1);
                end else begin
                    // number not present in the table
                    n_state = ST_DONE;
                    case (r_op)
                        OP_OPEN: begin
                            if (w_full) begin
                                n_res_status = STAT_TOO_MANY;
                            end else begin
                                w_ctl.wr_en  = 1'b1;
                                w_ctl.cnt_op = CNT_INC;
                                w_wr_addr    = w_count[AW-1:0];
                                w_wr_data    = '{logical:   r_num,
                                                 device:    r_dev,
                                                 secondary: r_sec | SA_FLAGS};
                            end
                        end
                        OP_LOOKUP: begin
                            n_res_status = STAT_NOT_OPEN;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_MOVE_RD: begin
                w_ctl.rd_en = 1'b1;
                w_rd_addr   = w_last[AW-1:0];
                n_state     = ST_MOVE_WR;
            end

            ST_MOVE_WR: begin
                // last entry fills the freed slot
                w_ctl.wr_en  = 1'b1;
                w_ctl.cnt_op = CNT_DEC;
                w_wr_addr    = r_pend_idx;
                w_wr_data    = w_rd_data;
                n_state      = ST_DONE;
            end

            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_dev    = r_res_dev;
                    n_out_sec    = r_res_sec;
                    n_out_count  = w_cnt_ext[COUNT_W-1:0];
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_num        <= n_num;
        r_dev        <= n_dev;
        r_sec        <= n_sec;
        r_idx        <= n_idx;
        r_pend_idx   <= n_pend_idx;
        r_res_status <= n_res_status;
        r_res_dev    <= n_res_dev;
        r_res_sec    <= n_res_sec;
        r_out_status <= n_out_status;
        r_out_dev    <= n_out_dev;
        r_out_sec    <= n_out_sec;
        r_out_count  <= n_out_count;
    end

    assign o_stall           = r_state != ST_IDLE;
    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_found_device    = r_out_dev;
    assign o_found_secondary = r_out_sec;
    assign o_open_count      = r_out_count;

    `LFT_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, w_count <= CW'(TABLE_DEPTH), "count above depth")
    `LFT_ASSERT_SAME(a_no_write_idle, i_clk, i_rst_n, r_state == ST_IDLE, !w_ctl.wr_en, "table write while idle")
    `LFT_ASSERT_SAME(a_full_status, i_clk, i_rst_n, (r_state == ST_SEARCH) && (n_res_status == STAT_TOO_MANY), w_full, "too many files on a table with room")
    `LFT_ASSERT_NEXT(a_result_load, i_clk, i_rst_n, (r_state == ST_DONE) && (!r_out_valid || !i_stall), r_out_valid && (r_state == ST_IDLE), "result not loaded")

endmodule
